>>> rtl/ciag_pkg.sv
`default_nettype none
package ciag_pkg;

  // Register index codes on the configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 17;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BATCH_COUNT   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_IMAGE_WIDTH   = 3'd2,
    REG_CHANNEL_ELEMS = 3'd3,
    REG_KERNEL_ROWS   = 3'd4,
    REG_KERNEL_COLS   = 3'd5,
    REG_ROW_STRIDE    = 3'd6,
    REG_COL_STRIDE    = 3'd7
  } cfg_reg_t;

  // Field widths
  localparam int unsigned BATCH_CNT_W = 9;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned CHAN_W      = 17;
  localparam int unsigned KER_W       = 4;
  localparam int unsigned BATCH_W     = 8;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned OFFSET_W    = 48;
  localparam int unsigned TAP_W       = 3;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 56;

  // Shared multiplier operand widths
  localparam int unsigned MUL_A_W = 35;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Window base (position times stride)
  localparam int unsigned BASE_W = POS_W + KER_W;

endpackage
`default_nettype wire

>>> rtl/conv_indirection_address_gen_top.sv
`default_nettype none
// Indirection buffer generator for an indirect convolution over a row-major
// tensor [batch][row][col][channel_elems].
// Input stream (in_*): one item names an output window by batch, output row
// and output column. Output stream (out_*): one item per kernel tap, kernel
// row outer and kernel column inner, carrying the element offset of the tap
// pixel; tlast marks the final tap. A window outside the output grid, or a
// bad kernel or stride setting, gives one item with tuser set, tlast set and
// zero data.
// Sequencing: one multiplier is shared by a sequencer. After an item is
// taken, the steps S_ROW, S_COL, S_CHK, S_RW, S_OFF and S_STEP compute the
// window bases, the range checks, the first offset and the row step; then
// one tap item is produced per cycle while the output register can take it.
// A settings error goes from idle straight to the error step, a grid error after S_CHK.
// in_tready is high only while the sequencer is idle.
// The output register holds a result until it is taken; a stall on out_tready
// holds the sequencer in S_EMIT and S_ERR, but a new item is still taken while
// the last result waits. Reset (rst_n low, synchronous) empties the output and
// sets every configuration register to 1. Write configuration only while idle.
module conv_indirection_address_gen_top #(
  parameter int unsigned MAX_KERNEL = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration write port
  input  wire logic                               cfg_we,
  input  wire logic [ciag_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [ciag_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // tdata: batch_index[7:0], out_row[19:8], out_col[31:20]
  input  wire logic [ciag_pkg::IN_DATA_W-1:0]     in_tdata,
  // output stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // tdata: elem_offset[47:0], tap_row[50:48], tap_col[53:51], zero[55:54]
  output logic [ciag_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                    out_tlast,   // last_tap
  output logic                                    out_tuser    // range_error
);

  typedef enum logic [3:0] {
    S_IDLE, S_ROW, S_COL, S_CHK, S_RW, S_OFF, S_STEP, S_EMIT, S_ERR
  } state_t;

  localparam int unsigned DIM_W    = ciag_pkg::DIM_W;
  localparam int unsigned KER_W    = ciag_pkg::KER_W;
  localparam int unsigned OFFSET_W = ciag_pkg::OFFSET_W;
  localparam int unsigned TAP_W    = ciag_pkg::TAP_W;
  localparam int unsigned BASE_W   = ciag_pkg::BASE_W;
  localparam int unsigned MUL_A_W  = ciag_pkg::MUL_A_W;
  localparam int unsigned MUL_B_W  = ciag_pkg::MUL_B_W;
  localparam int unsigned MUL_P_W  = ciag_pkg::MUL_P_W;
  localparam logic [KER_W-1:0] KMAX = KER_W'(MAX_KERNEL);

  // configuration registers
  logic [ciag_pkg::BATCH_CNT_W-1:0] batch_count_r;
  logic [DIM_W-1:0]                 image_height_r, image_width_r;
  logic [ciag_pkg::CHAN_W-1:0]      channel_elems_r;
  logic [KER_W-1:0]                 kernel_rows_r, kernel_cols_r;
  logic [KER_W-1:0]                 row_stride_r, col_stride_r;

  // sequencer state
  state_t                          state_r, state_nxt;
  logic [ciag_pkg::BATCH_W-1:0]    batch_r, batch_nxt;
  logic [ciag_pkg::POS_W-1:0]      row_r, row_nxt, col_r, col_nxt;
  logic [BASE_W-1:0]               rbase_r, rbase_nxt, cbase_r, cbase_nxt;
  logic [MUL_A_W-1:0]              acc_r, acc_nxt;
  logic [OFFSET_W-1:0]             off_r, off_nxt, row_off_r, row_off_nxt;
  logic [OFFSET_W-1:0]             step_r, step_nxt;
  logic [TAP_W-1:0]                kr_r, kr_nxt, kc_r, kc_nxt;

  // output register
  logic                            out_valid_r, out_valid_nxt;
  logic [OFFSET_W-1:0]             out_off_r, out_off_nxt;
  logic [TAP_W-1:0]                out_tr_r, out_tr_nxt, out_tc_r, out_tc_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            out_err_r, out_err_nxt;

  // shared multiplier
  logic [MUL_A_W-1:0]              mul_a;
  logic [MUL_B_W-1:0]              mul_b;
  logic [MUL_P_W-1:0]              mul_p;

  logic                            cfg_bad, grid_bad, out_free;
  logic                            kc_end, kr_end;

  // configuration writes keep the low bits of the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_count_r   <= ciag_pkg::BATCH_CNT_W'(1);
      image_height_r  <= DIM_W'(1);
      image_width_r   <= DIM_W'(1);
      channel_elems_r <= ciag_pkg::CHAN_W'(1);
      kernel_rows_r   <= KER_W'(1);
      kernel_cols_r   <= KER_W'(1);
      row_stride_r    <= KER_W'(1);
      col_stride_r    <= KER_W'(1);
    end else if (cfg_we) begin
      case (ciag_pkg::cfg_reg_t'(cfg_addr))
        ciag_pkg::REG_BATCH_COUNT:   batch_count_r   <= cfg_wdata[ciag_pkg::BATCH_CNT_W-1:0];
        ciag_pkg::REG_IMAGE_HEIGHT:  image_height_r  <= cfg_wdata[DIM_W-1:0];
        ciag_pkg::REG_IMAGE_WIDTH:   image_width_r   <= cfg_wdata[DIM_W-1:0];
        ciag_pkg::REG_CHANNEL_ELEMS: channel_elems_r <= cfg_wdata[ciag_pkg::CHAN_W-1:0];
        ciag_pkg::REG_KERNEL_ROWS:   kernel_rows_r   <= cfg_wdata[KER_W-1:0];
        ciag_pkg::REG_KERNEL_COLS:   kernel_cols_r   <= cfg_wdata[KER_W-1:0];
        ciag_pkg::REG_ROW_STRIDE:    row_stride_r    <= cfg_wdata[KER_W-1:0];
        ciag_pkg::REG_COL_STRIDE:    col_stride_r    <= cfg_wdata[KER_W-1:0];
        default: ;
      endcase
    end
  end

  // kernel and stride settings that no window can satisfy
  assign cfg_bad = (kernel_rows_r == '0) || (kernel_rows_r > KMAX) ||
                   (kernel_cols_r == '0) || (kernel_cols_r > KMAX) ||
                   (row_stride_r == '0) || (col_stride_r == '0) ||
                   ({1'b0, kernel_rows_r} > image_height_r[KER_W:0] &&
                    image_height_r < DIM_W'(MAX_KERNEL + 1)) ||
                   ({1'b0, kernel_cols_r} > image_width_r[KER_W:0] &&
                    image_width_r < DIM_W'(MAX_KERNEL + 1));

  // row < grid_h exactly when row*stride + kernel fits in the image
  assign grid_bad = ({1'b0, batch_r} >= batch_count_r) ||
                    ((BASE_W+1)'(rbase_r) + (BASE_W+1)'(kernel_rows_r) >
                     (BASE_W+1)'(image_height_r)) ||
                    ((BASE_W+1)'(cbase_r) + (BASE_W+1)'(kernel_cols_r) >
                     (BASE_W+1)'(image_width_r));

  // select operands of the shared multiplier by sequencer step
  always_comb begin
    case (state_r)
      S_ROW: begin
        mul_a = MUL_A_W'(row_r);
        mul_b = MUL_B_W'(row_stride_r);
      end
      S_COL: begin
        mul_a = MUL_A_W'(col_r);
        mul_b = MUL_B_W'(col_stride_r);
      end
      S_CHK: begin
        mul_a = MUL_A_W'(batch_r);
        mul_b = MUL_B_W'(image_height_r);
      end
      S_RW: begin
        mul_a = acc_r + MUL_A_W'(rbase_r);
        mul_b = MUL_B_W'(image_width_r);
      end
      S_OFF: begin
        mul_a = acc_r + MUL_A_W'(cbase_r);
        mul_b = MUL_B_W'(channel_elems_r);
      end
      S_STEP: begin
        mul_a = MUL_A_W'(image_width_r);
        mul_b = MUL_B_W'(channel_elems_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  assign out_free = !out_valid_r || out_tready;
  assign kc_end   = (KER_W'(kc_r) + KER_W'(1)) == kernel_cols_r;
  assign kr_end   = (KER_W'(kr_r) + KER_W'(1)) == kernel_rows_r;

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    batch_nxt     = batch_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    rbase_nxt     = rbase_r;
    cbase_nxt     = cbase_r;
    acc_nxt       = acc_r;
    off_nxt       = off_r;
    row_off_nxt   = row_off_r;
    step_nxt      = step_r;
    kr_nxt        = kr_r;
    kc_nxt        = kc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_off_nxt   = out_off_r;
    out_tr_nxt    = out_tr_r;
    out_tc_nxt    = out_tc_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          batch_nxt = in_tdata[7:0];
          row_nxt   = in_tdata[19:8];
          col_nxt   = in_tdata[31:20];
          state_nxt = cfg_bad ? S_ERR : S_ROW;
        end
      end
      S_ROW: begin
        rbase_nxt = mul_p[BASE_W-1:0];
        state_nxt = S_COL;
      end
      S_COL: begin
        cbase_nxt = mul_p[BASE_W-1:0];
        state_nxt = S_CHK;
      end
      S_CHK: begin
        acc_nxt   = mul_p[MUL_A_W-1:0];
        state_nxt = grid_bad ? S_ERR : S_RW;
      end
      S_RW: begin
        acc_nxt   = mul_p[MUL_A_W-1:0];
        state_nxt = S_OFF;
      end
      S_OFF: begin
        off_nxt     = mul_p[OFFSET_W-1:0];
        row_off_nxt = mul_p[OFFSET_W-1:0];
        state_nxt   = S_STEP;
      end
      S_STEP: begin
        step_nxt  = mul_p[OFFSET_W-1:0];
        kr_nxt    = '0;
        kc_nxt    = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // load one tap, then advance column, or wrap to the next row
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_off_nxt   = off_r;
          out_tr_nxt    = kr_r;
          out_tc_nxt    = kc_r;
          out_last_nxt  = kc_end && kr_end;
          out_err_nxt   = 1'b0;
          if (kc_end) begin
            kc_nxt      = '0;
            kr_nxt      = kr_r + TAP_W'(1);
            row_off_nxt = row_off_r + step_r;
            off_nxt     = row_off_r + step_r;
            if (kr_end) begin
              state_nxt = S_IDLE;
            end
          end else begin
            kc_nxt  = kc_r + TAP_W'(1);
            off_nxt = off_r + OFFSET_W'(channel_elems_r);
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_off_nxt   = '0;
          out_tr_nxt    = '0;
          out_tc_nxt    = '0;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      kr_r        <= '0;
      kc_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      kr_r        <= kr_nxt;
      kc_r        <= kc_nxt;
    end
    batch_r    <= batch_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    rbase_r    <= rbase_nxt;
    cbase_r    <= cbase_nxt;
    acc_r      <= acc_nxt;
    off_r      <= off_nxt;
    row_off_r  <= row_off_nxt;
    step_r     <= step_nxt;
    out_off_r  <= out_off_nxt;
    out_tr_r   <= out_tr_nxt;
    out_tc_r   <= out_tc_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_tc_r, out_tr_r, out_off_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

`ifndef SYNTHESIS
  // an error item is a lone, zeroed item
  a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("error item not zeroed or not last");

  // a taken item keeps the sequencer busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready after accept");

  // results are only loaded by the emit and error steps
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == S_EMIT) || ($past(state_r) == S_ERR))
    else $error("output loaded outside emit or error step");
`endif

endmodule
`default_nettype wire
